FILE: rtl/core/ipd_frame_parser_unit_assert.svh
`ifndef IPD_FRAME_PARSER_UNIT_ASSERT_SVH
`define IPD_FRAME_PARSER_UNIT_ASSERT_SVH

// implication checked in the same cycle, ignored while in reset
`define IPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle, ignored while in reset
`define IPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ipd_fp_pkg.sv
package ipd_fp_pkg;

    // parser phases
    localparam logic [2:0] PH_PREFIX  = 3'd0;
    localparam logic [2:0] PH_ID      = 3'd1;
    localparam logic [2:0] PH_COMMA   = 3'd2;
    localparam logic [2:0] PH_LENGTH  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // match status codes
    localparam logic [1:0] ST_NOMATCH    = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_COMPLETE   = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [2:0] HDR_LEN  = 3'd5;
    localparam logic [2:0] HDR_LAST = 3'd4;

    // register word index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [15:0] CAP_RESET = 16'd1024;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  conn_id;
        logic [15:0] length;
        logic [7:0]  pbyte;
        logic [15:0] pindex;
        logic        store;
    } result_t;

    // "+IPD," header text
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h2B;
            3'd1:    ch = 8'h49;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h44;
            3'd4:    ch = 8'h2C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/core/ipd_fp_cfg.sv
module ipd_fp_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] capacity
);

    logic [15:0] cap_reg;
    logic [15:0] cap_next;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == ipd_fp_pkg::REG_CAPACITY);

    always_comb
    begin
        cap_next = cap_reg;
        if (wr_en)
        begin
            cap_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= ipd_fp_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata   = (paddr[2] == ipd_fp_pkg::REG_CAPACITY) ? {16'd0, cap_reg} : 32'd0;
    assign pready   = 1'b1;
    assign capacity = cap_reg;

endmodule

FILE: rtl/core/ipd_fp_in_stage.sv
module ipd_fp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] rx_char,
    input  logic       take,
    output logic       in_ready,
    output logic       s1_valid,
    output logic [7:0] s1_char
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic [7:0] char_next;
    logic       accept;

    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            char_next  = rx_char;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign s1_valid = valid_reg;
    assign s1_char  = char_reg;

endmodule

FILE: rtl/core/ipd_fp_core.sv
`include "ipd_frame_parser_unit_assert.svh"

module ipd_fp_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          char_in,
    input  logic [15:0]         capacity,
    output ipd_fp_pkg::result_t res
);

    localparam int AW = LENGTH_BITS + 4;
    localparam int EW = LENGTH_BITS + 16;

    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;
    logic [2:0]             pos_reg;
    logic [2:0]             pos_next;
    logic [2:0]             conn_reg;
    logic [2:0]             conn_next;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [LENGTH_BITS-1:0] len_next;
    logic [LENGTH_BITS-1:0] cnt_reg;
    logic [LENGTH_BITS-1:0] cnt_next;

    logic [LENGTH_BITS-1:0] cnt_inc;
    logic [LENGTH_BITS-1:0] len_acc;
    logic [AW-1:0]          acc_wide;
    logic [7:0]             digit;
    logic [1:0]             status;
    logic [7:0]             pbyte;
    logic [LENGTH_BITS-1:0] pindex;
    logic                   store;
    logic [EW-1:0]          len_ext;
    logic [EW-1:0]          idx_ext;
    logic [EW-1:0]          cnt_ext;
    logic [EW-1:0]          cap_ext;

    assign digit   = char_in - ipd_fp_pkg::CH_ZERO;
    assign cnt_inc = cnt_reg + 1'b1;

    // length * 10 + digit, saturating at all ones
    assign acc_wide = (AW'(len_reg) << 3) + (AW'(len_reg) << 1) + AW'(digit[3:0]);
    assign len_acc  = (acc_wide[AW-1:LENGTH_BITS] != '0) ? '1 : acc_wide[LENGTH_BITS-1:0];

    assign cnt_ext = EW'(cnt_reg);
    assign cap_ext = EW'(capacity);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        conn_next  = conn_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        status     = ipd_fp_pkg::ST_NOMATCH;
        pbyte      = 8'd0;
        pindex     = '0;
        store      = 1'b0;
        case (phase_reg)
            ipd_fp_pkg::PH_PREFIX:
            begin
                if (pos_reg < ipd_fp_pkg::HDR_LEN && char_in == ipd_fp_pkg::hdr_char(pos_reg))
                begin
                    pos_next = pos_reg + 3'd1;
                    status   = ipd_fp_pkg::ST_INCOMPLETE;
                    if (pos_reg == ipd_fp_pkg::HDR_LAST)
                    begin
                        phase_next = ipd_fp_pkg::PH_ID;
                    end
                end
            end
            ipd_fp_pkg::PH_ID:
            begin
                if (char_in inside {[ipd_fp_pkg::CH_ZERO:ipd_fp_pkg::CH_FOUR]})
                begin
                    conn_next  = digit[2:0];
                    phase_next = ipd_fp_pkg::PH_COMMA;
                    status     = ipd_fp_pkg::ST_INCOMPLETE;
                end
            end
            ipd_fp_pkg::PH_COMMA:
            begin
                if (char_in == ipd_fp_pkg::CH_COMMA)
                begin
                    len_next   = '0;
                    phase_next = ipd_fp_pkg::PH_LENGTH;
                    status     = ipd_fp_pkg::ST_INCOMPLETE;
                end
            end
            ipd_fp_pkg::PH_LENGTH:
            begin
                if (char_in == ipd_fp_pkg::CH_COLON && len_reg != '0)
                begin
                    phase_next = ipd_fp_pkg::PH_PAYLOAD;
                    status     = ipd_fp_pkg::ST_INCOMPLETE;
                end
                else if (char_in inside {[ipd_fp_pkg::CH_ZERO:ipd_fp_pkg::CH_NINE]})
                begin
                    len_next = len_acc;
                    status   = ipd_fp_pkg::ST_INCOMPLETE;
                end
            end
            ipd_fp_pkg::PH_PAYLOAD:
            begin
                pbyte    = char_in;
                pindex   = cnt_reg;
                store    = cnt_ext < cap_ext;
                cnt_next = cnt_inc;
                status   = (cnt_inc == len_reg) ? ipd_fp_pkg::ST_COMPLETE
                                                : ipd_fp_pkg::ST_INCOMPLETE;
            end
            default:
            begin
                status = ipd_fp_pkg::ST_NOMATCH;
            end
        endcase

        // mismatch or finished frame restarts the header search
        if (status != ipd_fp_pkg::ST_INCOMPLETE)
        begin
            phase_next = ipd_fp_pkg::PH_PREFIX;
            pos_next   = 3'd0;
            cnt_next   = '0;
        end
    end

    assign len_ext = EW'(len_next);
    assign idx_ext = EW'(pindex);

    always_comb
    begin
        res.status  = status;
        res.conn_id = conn_next;
        res.length  = len_ext[15:0];
        res.pbyte   = pbyte;
        res.pindex  = idx_ext[15:0];
        res.store   = store;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ipd_fp_pkg::PH_PREFIX;
            pos_reg   <= 3'd0;
            conn_reg  <= 3'd0;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            conn_reg  <= conn_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    `IPD_ASSERT_SAME(a_store_only_payload, res.store, phase_reg == ipd_fp_pkg::PH_PAYLOAD, "store outside payload")
    `IPD_ASSERT_NEXT(a_complete_restarts, fire && res.status == ipd_fp_pkg::ST_COMPLETE, phase_reg == ipd_fp_pkg::PH_PREFIX && cnt_reg == '0, "no restart after frame")
    `IPD_ASSERT_SAME(a_header_done, phase_reg != ipd_fp_pkg::PH_PREFIX, pos_reg == ipd_fp_pkg::HDR_LEN, "header position lost")
    `IPD_ASSERT_SAME(a_payload_len, phase_reg == ipd_fp_pkg::PH_PAYLOAD, len_reg != '0, "payload with zero length")

endmodule

FILE: rtl/core/ipd_fp_out_stage.sv
module ipd_fp_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ipd_fp_pkg::result_t res_in,
    input  logic                out_ready,
    output logic                out_valid,
    output ipd_fp_pkg::result_t res_out
);

    logic                valid_reg;
    logic                valid_next;
    ipd_fp_pkg::result_t res_reg;
    ipd_fp_pkg::result_t res_next;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = res_in;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: rtl/core/ipd_frame_parser_unit.sv
// frame parser for "+IPD,<id>,<length>:<payload>" streams, one received byte per item
// input channel: rx_char with in_valid / in_ready
// output channel: match_status, connection_id, payload_length, payload_byte,
//   payload_index, store_enable with out_valid / out_ready, one result per input item
// apb port: buffer_capacity at byte address 0, written in the access cycle,
//   reads return the register, pready tied high
// path: an accepted item sits in the input register, then passes the parse logic into
//   the result register, which drives the output channel
// throughput: one item per cycle while the output is not stalled, set by the single parse-state update per byte
// reset: parser waits for the '+' of a new header, capacity reads 1024,
//   both stage registers empty
// when out_ready is low the result register holds, the input register still takes
//   one more item, and in_ready drops once both are full
// store_enable is set only for payload bytes whose index is below buffer_capacity
module ipd_frame_parser_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  match_status,
    output logic [2:0]  connection_id,
    output logic [15:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic        store_enable,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                s1_valid;
    logic [7:0]          s1_char;
    logic                advance;
    logic [15:0]         capacity;
    ipd_fp_pkg::result_t res_comb;
    ipd_fp_pkg::result_t res_q;

    // item moves to the result register when that register is free or draining
    assign advance = s1_valid && (!out_valid || out_ready);

    ipd_fp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    ipd_fp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .rx_char  (rx_char),
        .take     (advance),
        .in_ready (in_ready),
        .s1_valid (s1_valid),
        .s1_char  (s1_char)
    );

    ipd_fp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .char_in  (s1_char),
        .capacity (capacity),
        .res      (res_comb)
    );

    ipd_fp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_comb),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    assign match_status   = res_q.status;
    assign connection_id  = res_q.conn_id;
    assign payload_length = res_q.length;
    assign payload_byte   = res_q.pbyte;
    assign payload_index  = res_q.pindex;
    assign store_enable   = res_q.store;

endmodule
